/* sv/rll_pkg.sv */
// Shared types and codes for the refcounted LRU list unit
`timescale 1ns / 1ps
package rll_pkg;
	localparam int ENTRIES = 16;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_TOUCH   = 3'd1;
	localparam logic [2:0] OP_PURGE   = 3'd2;
	localparam logic [2:0] OP_ACQUIRE = 3'd3;
	localparam logic [2:0] OP_RELEASE = 3'd4;
	localparam logic [2:0] OP_COLLECT = 3'd5;
	localparam logic [2:0] OP_HOLD    = 3'd6;
	localparam logic [2:0] OP_LINKLRU = 3'd7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_NOFREE    = 3'd2;
	localparam logic [2:0] ST_UNLISTED  = 3'd3;
	localparam logic [2:0] ST_SATURATED = 3'd4;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] entry_index;
		logic [4:0] keep_free;
	} in_item_t;

	typedef struct packed {
		logic [3:0] result_entry;
		logic       evicted;
		logic       now_free;
		logic [4:0] free_count_out;
		logic [2:0] status;
		logic       last;
	} out_item_t;

	// datapath commands
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_LOAD   = 3'd1; // latch item, clear emitted flag
	localparam logic [2:0] CMD_EXEC   = 3'd2; // apply a non-collect op
	localparam logic [2:0] CMD_CSTART = 3'd3; // start collect walk at LRU end
	localparam logic [2:0] CMD_CSTEP  = 3'd4; // one collect step
	localparam logic [2:0] CMD_CFIN   = 3'd5; // build final collect result

	typedef struct packed {
		logic [2:0] cmd;
	} dp_cmd_t;

	typedef struct packed {
		logic is_collect;
		logic walk_done;  // free count at or below target
		logic walk_fail;  // reached head or step limit
		logic emit;       // current step evicts an entry
		logic emitted;    // collect already produced a result
		logic last_evict; // eviction at this step ends the walk
	} dp_stat_t;
endpackage

/* sv/rll_datapath.sv */
// Link, count and listed storage with the operation datapath
`timescale 1ns / 1ps
module rll_datapath #(
	parameter int REF_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rll_pkg::in_item_t  in_item,
	input  rll_pkg::dp_cmd_t   cmd,
	output rll_pkg::dp_stat_t  stat,
	output rll_pkg::out_item_t res
);
	localparam int ENTRIES = rll_pkg::ENTRIES;
	localparam int IW = $clog2(ENTRIES + 1);
	localparam int CW = $clog2(ENTRIES + 2);
	localparam logic [IW-1:0] HEAD = IW'(ENTRIES);
	localparam logic [REF_BITS-1:0] RMAX = '1;

	logic [IW-1:0]       next_q [ENTRIES+1];
	logic [IW-1:0]       prev_q [ENTRIES+1];
	logic [ENTRIES-1:0]  listed_q;
	logic [REF_BITS-1:0] cnt_q  [ENTRIES];
	logic [CW-1:0]       free_q;

	rll_pkg::in_item_t item_q;
	logic [IW-1:0] cur_q;
	logic [CW-1:0] steps_q;
	logic          emitted_q;
	logic          valid_e;
	logic [IW-1:0] e;

	assign e = IW'(item_q.entry_index);
	assign valid_e = (e < HEAD);

	logic [IW-1:0] ci;
	logic [REF_BITS-1:0] cur_cnt;
	assign ci = (cur_q < HEAD) ? cur_q : '0;
	assign cur_cnt = cnt_q[ci[$clog2(ENTRIES)-1:0]];

	logic [CW-1:0] tgt;
	assign tgt = CW'(item_q.keep_free);

	assign stat.is_collect = (item_q.op == rll_pkg::OP_COLLECT);
	assign stat.walk_done  = (free_q <= tgt);
	assign stat.walk_fail  = (cur_q >= HEAD) || (steps_q > CW'(ENTRIES));
	assign stat.emit       = (cur_cnt == '0);
	assign stat.emitted    = emitted_q;
	assign stat.last_evict = ((free_q - CW'(1)) <= tgt);

	logic [$clog2(ENTRIES)-1:0] ex;
	assign ex = e[$clog2(ENTRIES)-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ENTRIES; i++) begin
				next_q[i] <= HEAD;
				prev_q[i] <= HEAD;
			end
			for (int i = 0; i < ENTRIES; i++) cnt_q[i] <= '0;
			listed_q  <= '0;
			free_q    <= '0;
			cur_q     <= HEAD;
			steps_q   <= '0;
			emitted_q <= 1'b0;
			item_q    <= '0;
			res       <= '0;
		end else begin
			case (cmd.cmd)
			rll_pkg::CMD_LOAD: begin
				item_q    <= in_item;
				emitted_q <= 1'b0;
			end
			rll_pkg::CMD_CSTART: begin
				cur_q   <= prev_q[HEAD];
				steps_q <= '0;
			end
			rll_pkg::CMD_CSTEP: begin
				if (stat.emit) begin
					next_q[prev_q[cur_q]] <= next_q[cur_q];
					prev_q[next_q[cur_q]] <= prev_q[cur_q];
					listed_q[ci[$clog2(ENTRIES)-1:0]] <= 1'b0;
					free_q <= free_q - 1'b1;
					emitted_q <= 1'b1;
					res <= '{result_entry: 4'(ci), evicted: 1'b1, now_free: 1'b0,
						free_count_out: 5'(free_q - 1'b1),
						status: rll_pkg::ST_OK, last: stat.last_evict};
				end
				cur_q   <= prev_q[cur_q];
				steps_q <= steps_q + 1'b1;
			end
			rll_pkg::CMD_CFIN: begin
				res <= '{result_entry: 4'd0, evicted: 1'b0, now_free: 1'b0,
					free_count_out: 5'(free_q),
					status: (stat.walk_done ? rll_pkg::ST_OK : rll_pkg::ST_NOFREE),
					last: 1'b1};
			end
			rll_pkg::CMD_EXEC: begin
				logic [2:0] st;
				logic nf;
				logic [IW-1:0] n, p, first, lastn;
				logic lst;
				logic [REF_BITS-1:0] c;
				logic [CW-1:0] fc;
				st = rll_pkg::ST_OK;
				nf = 1'b0;
				n = next_q[e];
				p = prev_q[e];
				lst = listed_q[ex];
				c = cnt_q[ex];
				first = next_q[HEAD];
				lastn = prev_q[HEAD];
				fc = free_q;
				if (valid_e) begin
					case (item_q.op)
					rll_pkg::OP_ADD, rll_pkg::OP_TOUCH, rll_pkg::OP_ACQUIRE: begin
						logic mv;
						mv = 1'b0;
						if (item_q.op == rll_pkg::OP_ADD) begin
							mv = 1'b1;
							cnt_q[ex] <= REF_BITS'(1);
							listed_q[ex] <= 1'b1;
							if (lst && c == '0 && free_q != '0) fc = free_q - 1'b1;
						end else if (item_q.op == rll_pkg::OP_TOUCH) begin
							mv = lst;
						end else if (c == '0 && !lst) begin
							st = rll_pkg::ST_UNLISTED;
						end else if (c == RMAX) begin
							st = rll_pkg::ST_SATURATED;
						end else begin
							if (c == '0 && free_q != '0) fc = free_q - 1'b1;
							cnt_q[ex] <= c + 1'b1;
							mv = lst;
						end
						if (mv) begin
							if (lst) begin
								if (first == e) begin
									// already at MRU end: no change
								end else begin
									next_q[p] <= n;
									prev_q[n] <= p;
									next_q[e] <= first;
									prev_q[e] <= HEAD;
									prev_q[first] <= e;
									next_q[HEAD] <= e;
								end
							end else begin
								next_q[e] <= first;
								prev_q[e] <= HEAD;
								prev_q[first] <= e;
								next_q[HEAD] <= e;
							end
						end
					end
					rll_pkg::OP_PURGE, rll_pkg::OP_HOLD: begin
						if (lst) begin
							next_q[p] <= n;
							prev_q[n] <= p;
							listed_q[ex] <= 1'b0;
							if (c == '0 && free_q != '0) fc = free_q - 1'b1;
						end
						if (item_q.op == rll_pkg::OP_HOLD) cnt_q[ex] <= REF_BITS'(1);
					end
					rll_pkg::OP_RELEASE: begin
						if (c == '0) begin
							st = rll_pkg::ST_UNDERFLOW;
						end else begin
							cnt_q[ex] <= c - 1'b1;
							if (c == REF_BITS'(1)) begin
								nf = 1'b1;
								if (lst) fc = free_q + 1'b1;
							end
						end
					end
					default: begin
						if (lst) begin
							if (lastn != e) begin
								next_q[p] <= n;
								prev_q[n] <= p;
								next_q[e] <= HEAD;
								prev_q[e] <= lastn;
								next_q[lastn] <= e;
								prev_q[HEAD] <= e;
							end
						end else begin
							listed_q[ex] <= 1'b1;
							if (c == '0) fc = free_q + 1'b1;
							next_q[e] <= HEAD;
							prev_q[e] <= lastn;
							next_q[lastn] <= e;
							prev_q[HEAD] <= e;
						end
					end
					endcase
				end
				free_q <= fc;
				res <= '{result_entry: item_q.entry_index, evicted: 1'b0, now_free: nf,
					free_count_out: 5'(fc), status: st, last: 1'b1};
			end
			default: ;
			endcase
		end
	end
endmodule

/* sv/rll_ctrl.sv */
// Controller state machine for the refcounted LRU list unit
`timescale 1ns / 1ps
module rll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rll_pkg::dp_stat_t stat,
	output rll_pkg::dp_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;
	localparam logic [2:0] S_WOUT = 3'd4;

	logic [2:0] state_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_WOUT);

	always_comb begin
		cmd.cmd = rll_pkg::CMD_NONE;
		case (state_q)
		S_IDLE: if (in_valid) cmd.cmd = rll_pkg::CMD_LOAD;
		S_DEC:  cmd.cmd = stat.is_collect ? rll_pkg::CMD_CSTART : rll_pkg::CMD_EXEC;
		S_WALK: begin
			if (stat.walk_done || stat.walk_fail) begin
				if (!stat.walk_done || !stat.emitted) cmd.cmd = rll_pkg::CMD_CFIN;
			end else begin
				cmd.cmd = rll_pkg::CMD_CSTEP;
			end
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
			S_IDLE: if (in_valid) state_q <= S_DEC;
			S_DEC:  state_q <= stat.is_collect ? S_WALK : S_OUT;
			S_WALK: begin
				if (stat.walk_done || stat.walk_fail) begin
					state_q <= S_OUT;
				end else if (stat.emit) begin
					state_q <= stat.last_evict ? S_OUT : S_WOUT;
				end
			end
			S_OUT:  if (out_ready) state_q <= S_IDLE;
			S_WOUT: if (out_ready) state_q <= S_WALK;
			default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/refcounted_lru_list_unit.sv */
// Top level of the refcounted LRU list unit
//  channel  | signals                   | direction
//  in       | in_valid in_ready in_item | into the block
//  out      | out_valid out_ready out_item | out of the block
// Non-collect items return one result. Collect walks the list from the LRU end and
// returns one result per eviction; when no eviction ends the walk, a final result
// gives the free count and status.
// Reset clears all links, counts and listed bits at once.
// A stalled output holds the walk; no item is accepted until the last result leaves.
`timescale 1ns / 1ps
module refcounted_lru_list_unit #(
	parameter int REF_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rll_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output rll_pkg::out_item_t out_item
);
	rll_pkg::dp_cmd_t  cmd;
	rll_pkg::dp_stat_t stat;

	rll_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.stat, .cmd
	);

	rll_datapath #(.REF_BITS(REF_BITS)) u_dp (
		.clk, .arst_n, .in_item, .cmd, .stat, .res(out_item)
	);

`ifndef NO_ASSERTIONS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("double accept");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.last) |=> in_ready)
		else $error("no return to idle");
`endif
endmodule
